// ===== sv/unlc_pkg.sv =====
`default_nettype none
package unlc_pkg;

  localparam logic [1:0] FMT_UNIX = 2'd0;
  localparam logic [1:0] FMT_MAC  = 2'd1;
  localparam logic [1:0] FMT_WIN  = 2'd2;

  localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
  localparam logic [1:0] REG_TARGET_FORMAT = 2'd1;
  localparam logic [1:0] REG_SWAP_BYTES    = 2'd2;

  localparam logic [15:0] UNIT_LF   = 16'h000A;
  localparam logic [15:0] UNIT_CR   = 16'h000D;
  localparam logic [7:0]  BOM_FIRST = 8'hFE;

  typedef struct packed {
    logic [1:0] src;
    logic [1:0] dst;
    logic       swap;
  } cfg_t;

  // One queued request: the converted unit, whether a CR goes out ahead of
  // it, and the stream byte order.
  typedef struct packed {
    logic [15:0] unit;
    logic        ins_cr;
    logic        be;
  } unit_req_t;

  function automatic logic [1:0] decode_format(input logic [1:0] code);
    logic [1:0] f;
    if (code[1]) f = FMT_WIN;
    else         f = {1'b0, code[0]};
    return f;
  endfunction

  function automatic logic [15:0] eol_of(input logic [1:0] fmt);
    logic [15:0] u;
    if (fmt == FMT_MAC) u = UNIT_CR;
    else                u = UNIT_LF;
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== sv/unlc_front.sv =====
`default_nettype none
module unlc_front import unlc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      accept,
  input  wire logic [7:0] b0,
  input  wire logic [7:0] b1,
  output unit_req_t      req,
  output logic           req_wr
);

  logic order_known_r, order_known_nxt;
  logic big_endian_r, big_endian_nxt;
  logic be;
  logic [15:0] v;
  logic [15:0] unit;
  logic ins_cr;
  logic drop;

  always_comb begin
    big_endian_nxt  = big_endian_r;
    order_known_nxt = order_known_r;
    if (accept && !order_known_r) begin
      big_endian_nxt  = (b0 == BOM_FIRST);
      order_known_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_known_r <= 1'b0;
      big_endian_r  <= 1'b0;
    end else begin
      order_known_r <= order_known_nxt;
      big_endian_r  <= big_endian_nxt;
    end
  end

  // The first unit is read under the order it establishes.
  assign be = order_known_r ? big_endian_r : (b0 == BOM_FIRST);
  assign v  = be ? {b0, b1} : {b1, b0};

  always_comb begin
    unit   = v;
    ins_cr = 1'b0;
    drop   = 1'b0;
    if (cfg.src == cfg.dst) begin
      unit = v;
    end else if (cfg.src != FMT_WIN && cfg.dst != FMT_WIN) begin
      if (v == eol_of(cfg.src)) unit = eol_of(cfg.dst);
    end else if (cfg.dst == FMT_WIN) begin
      if (v == eol_of(cfg.src)) begin
        unit   = UNIT_LF;
        ins_cr = 1'b1;
      end
    end else if (cfg.dst == FMT_UNIX) begin
      drop = (v == UNIT_CR);
    end else begin
      drop = (v == UNIT_LF);
    end
  end

  assign req.unit   = unit;
  assign req.ins_cr = ins_cr;
  assign req.be     = be;
  assign req_wr     = accept && !drop;

endmodule
`default_nettype wire

// ===== sv/unlc_fifo.sv =====
`default_nettype none
module unlc_fifo import unlc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr,
  input  wire unit_req_t wr_data,
  input  wire logic      rd,
  output unit_req_t      rd_data,
  output logic           full,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  unit_req_t mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_wr, do_rd;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_data = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == LAST) ? '0 : wp_r + 1'b1;
    if (do_rd) rp_nxt = (rp_r == LAST) ? '0 : rp_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

// ===== sv/unlc_back.sv =====
`default_nettype none
module unlc_back import unlc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      swap,
  input  wire unit_req_t head,
  input  wire logic      head_empty,
  output logic           head_rd,
  input  wire logic      pop,
  output logic           empty,
  output logic [7:0]     first_byte,
  output logic [7:0]     second_byte,
  output logic           last_of_run
);

  logic out_valid_r, out_valid_nxt;
  logic cr_done_r, cr_done_nxt;
  logic [7:0] a_r, a_nxt, b_r, b_nxt;
  logic last_r, last_nxt;
  logic load;
  logic [15:0] u;
  logic [7:0] lo, hi, a, b;

  assign load = !head_empty && (!out_valid_r || pop);

  always_comb begin
    if (head.ins_cr && !cr_done_r) u = UNIT_CR;
    else                           u = head.unit;
    lo = u[7:0];
    hi = u[15:8];
    a  = head.be ? hi : lo;
    b  = head.be ? lo : hi;
    if (swap) begin
      a_nxt = b;
      b_nxt = a;
    end else begin
      a_nxt = a;
      b_nxt = b;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    cr_done_nxt   = cr_done_r;
    last_nxt      = last_r;
    head_rd       = 1'b0;
    if (pop && out_valid_r) out_valid_nxt = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      // Hold the head while its CR goes out, advance after the unit itself.
      if (head.ins_cr && !cr_done_r) begin
        cr_done_nxt = 1'b1;
        last_nxt    = 1'b0;
      end else begin
        cr_done_nxt = 1'b0;
        last_nxt    = 1'b1;
        head_rd     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cr_done_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cr_done_r   <= cr_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
    last_r <= last_nxt;
  end

  assign empty       = !out_valid_r;
  assign first_byte  = a_r;
  assign second_byte = b_r;
  assign last_of_run = last_r;

endmodule
`default_nettype wire

// ===== sv/utf16_newline_converter.sv =====
// UTF-16 line-ending converter.
// Input queue: present a code unit on in_first_byte/in_second_byte and raise
// in_push; the request is taken on a clock edge where in_full is low.
// Result queue: while out_empty is low the oldest unit is on the out_ ports;
// raise out_pop to take it. out_last_of_run marks the final unit of an input
// request (low only on an inserted CR).
// Configuration: cfg_index selects source format, target format or byte
// swap; cfg_data is written when cfg_valid is high (cfg_ready is always high).
// Write it only while the block is drained.
// An accepted unit passes through the queue and then the output register
// before out_empty goes low. One unit is taken every cycle while in_full
// is low; a line end that gains a CR holds the output register first with
// the CR and then with the LF, as the back end has a single output slot.
// The queue between front and back end absorbs the inserted CR and short
// output stalls; once it fills, in_full rises until out_pop drains results.
// Reset (rst_n low, synchronous) empties both queues, forgets the detected
// byte order and clears the configuration to unix, unix, no swap.
`default_nettype none
module utf16_newline_converter import unlc_pkg::*; #(
  parameter int FIFO_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_first_byte,
  input  wire logic [7:0] in_second_byte,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_first_byte,
  output logic [7:0]      out_second_byte,
  output logic            out_last_of_run,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_data
);

  logic [1:0] src_r, src_nxt, dst_r, dst_nxt;
  logic swap_r, swap_nxt;
  cfg_t cfg;
  logic accept;
  unit_req_t front_req, head;
  logic front_wr, head_rd, fifo_full, fifo_empty;

  assign cfg_ready = 1'b1;

  // Decode register writes; unknown indexes are dropped.
  always_comb begin
    src_nxt  = src_r;
    dst_nxt  = dst_r;
    swap_nxt = swap_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_FORMAT: src_nxt  = cfg_data;
        REG_TARGET_FORMAT: dst_nxt  = cfg_data;
        REG_SWAP_BYTES:    swap_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= FMT_UNIX;
      dst_r  <= FMT_UNIX;
      swap_r <= 1'b0;
    end else begin
      src_r  <= src_nxt;
      dst_r  <= dst_nxt;
      swap_r <= swap_nxt;
    end
  end

  // Format code three behaves as windows.
  assign cfg.src  = decode_format(src_r);
  assign cfg.dst  = decode_format(dst_r);
  assign cfg.swap = swap_r;

  assign in_full = fifo_full;
  assign accept  = in_push && !in_full;

  unlc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .accept (accept),
    .b0     (in_first_byte),
    .b1     (in_second_byte),
    .req    (front_req),
    .req_wr (front_wr)
  );

  unlc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (front_wr),
    .wr_data (front_req),
    .rd      (head_rd),
    .rd_data (head),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  unlc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .swap        (cfg.swap),
    .head        (head),
    .head_empty  (fifo_empty),
    .head_rd     (head_rd),
    .pop         (out_pop),
    .empty       (out_empty),
    .first_byte  (out_first_byte),
    .second_byte (out_second_byte),
    .last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

// ===== sv/unlc_checker.sv =====
`default_nettype none
module unlc_checker import unlc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [7:0] out_first_byte,
  input wire logic [7:0] out_second_byte,
  input wire logic       out_last_of_run
);

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_first_byte)
      && $stable(out_second_byte) && $stable(out_last_of_run)))
    else $error("stalled result changed");

  // Only an inserted CR unit is not last of its run.
  a_cr_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last_of_run) |->
      ((out_first_byte == UNIT_CR[7:0] && out_second_byte == UNIT_CR[15:8]) ||
       (out_first_byte == UNIT_CR[15:8] && out_second_byte == UNIT_CR[7:0])))
    else $error("non-final unit is not a CR");

  // An inserted CR is always followed by the LF of the same request.
  a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last_of_run) |=>
      (!out_empty && out_last_of_run))
    else $error("inserted CR not followed by its LF");

endmodule

bind utf16_newline_converter unlc_checker u_unlc_checker (.*);
`default_nettype wire

// ===== tb/utf16_newline_converter_tb.sv =====
`default_nettype none
module utf16_newline_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import unlc_pkg::*;

  // Format code three is not one of the named formats; the block must treat it as windows.
  localparam logic [1:0] FMT_CODE3 = 2'd3;
  localparam logic [1:0] SWAP_OFF  = 2'd0;
  localparam logic [1:0] SWAP_ON   = 2'd1;

  localparam int RESET_CYCLES     = 11;
  localparam int SETTLE_CYCLES    = 8;       // margin past the pending results so a dropped unit clears
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS     = 1600;
  localparam int CYCLE_LIMIT      = 400000;

  typedef enum logic [1:0] {CHK_MODEL, CHK_COPY, CHK_SWAP} check_kind_t;

  // One emitted code unit as it shows up on the result ports.
  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       run_end;
  } conv_unit_t;

  // Zero, one or two units caused by one request.
  typedef struct packed {
    logic [1:0] count;
    conv_unit_t lead;
    conv_unit_t trail;
  } conv_result_t;

  typedef struct {
    logic [1:0]  src;
    logic [1:0]  dst;
    logic [1:0]  swap;
    logic [15:0] code;
    check_kind_t kind;
  } dir_row_t;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       in_push        = 1'b0;
  logic       in_full;
  logic [7:0] in_first_byte  = 8'h00;
  logic [7:0] in_second_byte = 8'h00;
  logic       out_empty;
  logic       out_pop        = 1'b0;
  logic [7:0] out_first_byte;
  logic [7:0] out_second_byte;
  logic       out_last_of_run;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index      = 2'd0;
  logic [1:0] cfg_data       = 2'd0;

  // Converter state as the block should hold it.
  logic       seen_first = 1'b0;
  logic       stream_big = 1'b0;
  logic [1:0] cfg_src    = FMT_UNIX;
  logic [1:0] cfg_dst    = FMT_UNIX;
  logic       cfg_swap   = 1'b0;

  conv_unit_t expected_units[$];
  dir_row_t   directed_rows[$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  logic        sender_fast    = 1'b0;
  logic        receiver_fast  = 1'b0;
  logic        long_hold_req  = 1'b0;
  logic        stim_big_order = 1'b0;   // byte order the stimulus writes its units in

  utf16_newline_converter uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_first_byte   (in_first_byte),
    .in_second_byte  (in_second_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_first_byte  (out_first_byte),
    .out_second_byte (out_second_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("utf16_newline_converter_tb: FAIL");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    $display("[cycle %0d] mismatch: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Lay a 16-bit unit out in the detected stream order, then apply the byte swap.
  function automatic conv_unit_t place_bytes(input logic [15:0] v, input logic run_end);
    conv_unit_t u;
    u.byte_a  = stream_big ? v[15:8] : v[7:0];
    u.byte_b  = stream_big ? v[7:0] : v[15:8];
    u.run_end = run_end;
    if (cfg_swap) begin
      u.byte_a = u.byte_b;
      u.byte_b = stream_big ? v[15:8] : v[7:0];
    end
    return u;
  endfunction

  // Convert one accepted request; updates the byte-order state on the first unit.
  function automatic conv_result_t predict_unit(input logic [7:0] b0, input logic [7:0] b1);
    conv_result_t r;
    logic [15:0]  v;
    logic [1:0]   src;
    logic [1:0]   dst;
    logic [15:0]  src_eol;
    logic [15:0]  dst_eol;
    if (!seen_first) begin
      stream_big = (b0 == BOM_FIRST);
      seen_first = 1'b1;
    end
    v       = stream_big ? {b0, b1} : {b1, b0};
    src     = cfg_src[1] ? FMT_WIN : {1'b0, cfg_src[0]};
    dst     = cfg_dst[1] ? FMT_WIN : {1'b0, cfg_dst[0]};
    src_eol = (src == FMT_MAC) ? UNIT_CR : UNIT_LF;
    dst_eol = (dst == FMT_MAC) ? UNIT_CR : UNIT_LF;
    r.count = 2'd1;
    r.lead  = place_bytes(v, 1'b1);
    r.trail = '0;
    if (src == dst) begin
      // plain copy
    end else if (src != FMT_WIN && dst != FMT_WIN) begin
      if (v == src_eol) r.lead = place_bytes(dst_eol, 1'b1);
    end else if (dst == FMT_WIN) begin
      if (v == src_eol) begin
        r.count = 2'd2;
        r.lead  = place_bytes(UNIT_CR, 1'b0);
        r.trail = place_bytes(UNIT_LF, 1'b1);
      end
    end else if ((dst == FMT_UNIX && v == UNIT_CR) || (dst == FMT_MAC && v == UNIT_LF)) begin
      r.count = 2'd0;
    end
    return r;
  endfunction

  function automatic logic [15:0] stream_bytes(input logic [15:0] code);
    return stim_big_order ? code : {code[7:0], code[15:8]};
  endfunction

  // Bias toward line ends and near misses; the rest is any 16-bit value.
  function automatic logic [15:0] pick_unit();
    int unsigned roll;
    logic [15:0] v;
    roll = $urandom_range(0, 9);
    if (roll < 3)
      v = UNIT_LF;
    else if (roll < 6)
      v = UNIT_CR;
    else if (roll == 6)
      v = {8'($urandom_range(1, 255)), ($urandom_range(0, 1) != 0) ? UNIT_LF[7:0] : UNIT_CR[7:0]};
    else if (roll == 7)
      v = {($urandom_range(0, 1) != 0) ? UNIT_LF[7:0] : UNIT_CR[7:0], 8'h00};
    else
      v = 16'($urandom);
    return v;
  endfunction

  task automatic add_row(input logic [1:0] src, input logic [1:0] dst, input logic [1:0] swap,
                         input logic [15:0] code, input check_kind_t kind);
    dir_row_t row;
    row.src  = src;
    row.dst  = dst;
    row.swap = swap;
    row.code = code;
    row.kind = kind;
    directed_rows.push_back(row);
  endtask

  // Offer one request, hold it until taken, then queue what it should produce.
  task automatic send_request(input logic [7:0] b0, input logic [7:0] b1,
                              input check_kind_t kind);
    int unsigned  gap;
    conv_result_t pred;
    gap = sender_fast ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push        <= 1'b1;
    in_first_byte  <= b0;
    in_second_byte <= b1;
    do @(posedge clk); while (in_full);
    // Run the predictor even on typed rows so the byte-order state advances.
    pred = predict_unit(b0, b1);
    case (kind)
      CHK_COPY: expected_units.push_back({b0, b1, 1'b1});
      CHK_SWAP: expected_units.push_back({b1, b0, 1'b1});
      default: begin
        if (pred.count != 0) expected_units.push_back(pred.lead);
        if (pred.count == 2) expected_units.push_back(pred.trail);
      end
    endcase
  endtask

  // Drop the request line, wait out every pending result, then let a dropped unit clear.
  task automatic settle_block();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOURCE_FORMAT: cfg_src  = data;
      REG_TARGET_FORMAT: cfg_dst  = data;
      REG_SWAP_BYTES:    cfg_swap = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: pop with random stalls, check every unit against the oldest expectation.
  initial begin : result_side
    int unsigned stall;
    int unsigned taken;
    conv_unit_t  got;
    conv_unit_t  want;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        // Hold off long enough for the block to fill and raise in_full.
        out_pop <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        stall = receiver_fast ? 0 : $urandom_range(0, 14);
        if (stall != 0) begin
          out_pop <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      got = {out_first_byte, out_second_byte, out_last_of_run};
      if (expected_units.size() == 0) begin
        note_mismatch($sformatf("result %h %h last=%b with no request pending",
                                got.byte_a, got.byte_b, got.run_end));
      end else begin
        want = expected_units.pop_front();
        if (got.byte_a !== want.byte_a || got.byte_b !== want.byte_b ||
            got.run_end !== want.run_end)
          note_mismatch($sformatf("got %h %h last=%b, want %h %h last=%b",
                                  got.byte_a, got.byte_b, got.run_end,
                                  want.byte_a, want.byte_b, want.run_end));
      end
      taken++;
      // Switch between back-to-back pops and stalled pops now and then.
      if (taken % 40 == 0) receiver_fast = ($urandom_range(0, 3) == 0);
    end
  end

  // Request side: directed table, then random phases under random configurations.
  initial begin : request_side
    int unsigned sent;
    int unsigned phase;
    int unsigned span;
    logic [15:0] bytes;

    // The opening unit decides byte order for the whole run; let the seed pick it.
    stim_big_order = ($urandom_range(0, 1) != 0);

    // Byte-order mark first, then extremes and swap under a plain copy.
    add_row(FMT_UNIX,  FMT_UNIX,  SWAP_OFF, 16'hFEFF,  CHK_COPY);
    add_row(FMT_UNIX,  FMT_UNIX,  SWAP_OFF, 16'h0000,  CHK_COPY);
    add_row(FMT_UNIX,  FMT_UNIX,  SWAP_OFF, 16'hFFFF,  CHK_COPY);
    add_row(FMT_UNIX,  FMT_UNIX,  SWAP_OFF, UNIT_LF,   CHK_COPY);
    add_row(FMT_UNIX,  FMT_UNIX,  SWAP_ON,  16'h00FF,  CHK_SWAP);
    add_row(FMT_UNIX,  FMT_UNIX,  SWAP_ON,  16'hFF00,  CHK_SWAP);
    add_row(FMT_UNIX,  FMT_UNIX,  SWAP_ON,  16'hA55A,  CHK_SWAP);
    // Unix and mac trade their line ends; a nonzero high byte is no line end.
    add_row(FMT_UNIX,  FMT_MAC,   SWAP_OFF, UNIT_LF,   CHK_MODEL);
    add_row(FMT_UNIX,  FMT_MAC,   SWAP_OFF, UNIT_CR,   CHK_MODEL);
    add_row(FMT_UNIX,  FMT_MAC,   SWAP_OFF, 16'h0A00,  CHK_MODEL);
    add_row(FMT_MAC,   FMT_UNIX,  SWAP_ON,  UNIT_CR,   CHK_MODEL);
    add_row(FMT_MAC,   FMT_UNIX,  SWAP_ON,  UNIT_LF,   CHK_MODEL);
    // Going to windows inserts a CR ahead of the line end.
    add_row(FMT_UNIX,  FMT_WIN,   SWAP_OFF, UNIT_LF,   CHK_MODEL);
    add_row(FMT_UNIX,  FMT_WIN,   SWAP_OFF, 16'h0041,  CHK_MODEL);
    add_row(FMT_MAC,   FMT_WIN,   SWAP_ON,  UNIT_CR,   CHK_MODEL);
    add_row(FMT_MAC,   FMT_WIN,   SWAP_ON,  16'h0D00,  CHK_MODEL);
    // Leaving windows drops one half of each line end.
    add_row(FMT_WIN,   FMT_UNIX,  SWAP_OFF, UNIT_CR,   CHK_MODEL);
    add_row(FMT_WIN,   FMT_UNIX,  SWAP_OFF, UNIT_LF,   CHK_MODEL);
    add_row(FMT_WIN,   FMT_MAC,   SWAP_OFF, UNIT_LF,   CHK_MODEL);
    add_row(FMT_WIN,   FMT_MAC,   SWAP_OFF, UNIT_CR,   CHK_MODEL);
    add_row(FMT_WIN,   FMT_WIN,   SWAP_OFF, UNIT_CR,   CHK_COPY);
    // Format code three acts as windows on either side.
    add_row(FMT_CODE3, FMT_UNIX,  SWAP_OFF, UNIT_CR,   CHK_MODEL);
    add_row(FMT_UNIX,  FMT_CODE3, SWAP_OFF, UNIT_LF,   CHK_MODEL);
    add_row(FMT_CODE3, FMT_CODE3, SWAP_ON,  UNIT_LF,   CHK_SWAP);
    add_row(FMT_CODE3, FMT_MAC,   SWAP_OFF, UNIT_LF,   CHK_MODEL);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      // Reconfigure only with the block drained.
      if (directed_rows[i].src != cfg_src || directed_rows[i].dst != cfg_dst ||
          directed_rows[i].swap[0] != cfg_swap) begin
        settle_block();
        if (directed_rows[i].src != cfg_src)
          write_reg(REG_SOURCE_FORMAT, directed_rows[i].src);
        if (directed_rows[i].dst != cfg_dst)
          write_reg(REG_TARGET_FORMAT, directed_rows[i].dst);
        if (directed_rows[i].swap[0] != cfg_swap)
          write_reg(REG_SWAP_BYTES, directed_rows[i].swap);
      end
      bytes = stream_bytes(directed_rows[i].code);
      send_request(bytes[15:8], bytes[7:0], directed_rows[i].kind);
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      // Pause until every result is home, then pick a new configuration.
      settle_block();
      write_reg(REG_SOURCE_FORMAT, 2'($urandom_range(0, 3)));
      write_reg(REG_TARGET_FORMAT, 2'($urandom_range(0, 3)));
      write_reg(REG_SWAP_BYTES,    2'($urandom_range(0, 3)));
      if (phase == 2) begin
        // Stall the result side for a long stretch while requests keep coming.
        long_hold_req = 1'b1;
        sender_fast   = 1'b1;
        span          = 120;
      end else begin
        sender_fast = ($urandom_range(0, 3) == 0);
        span        = $urandom_range(20, 120);
      end
      repeat (span) begin
        bytes = stream_bytes(pick_unit());
        send_request(bytes[15:8], bytes[7:0], CHK_MODEL);
        sent++;
      end
      phase++;
    end

    settle_block();
    if (mismatch_count == 0)
      $display("utf16_newline_converter_tb: PASS");
    else
      $display("utf16_newline_converter_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== utf16_newline_converter.f =====
sv/unlc_pkg.sv
sv/unlc_front.sv
sv/unlc_fifo.sv
sv/unlc_back.sv
sv/utf16_newline_converter.sv
sv/unlc_checker.sv
tb/utf16_newline_converter_tb.sv
